@@ sv/ugbu_pkg.sv @@
package ugbu_pkg;

  // Store sizes: fixed by the 8-bit particle and cell fields
  localparam int MAX_PARTICLES = 256;
  localparam int MAX_CELLS     = 256;

  // Field widths
  localparam int PIDX_W  = 8;   // particle number
  localparam int CELL_W  = 8;   // cell index
  localparam int SLOT_W  = 8;   // slot within a cell list
  localparam int CNT_W   = 9;   // member count, 0..MAX_PARTICLES
  localparam int POS_W   = 24;  // signed position
  localparam int FRAC_W  = 8;   // fraction bits of a position
  localparam int QUO_W   = POS_W - FRAC_W - 1;  // integer part of a non-negative position
  localparam int SIZE_W  = 16;  // cell edge length
  localparam int GRID_W  = 9;   // column / row count
  localparam int ERR_W   = 2;

  localparam int LIST_AW = CELL_W + SLOT_W;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_CAPACITY = 3'd3;

  localparam logic [GRID_W-1:0] RST_COLUMN_COUNT  = 9'd16;
  localparam logic [GRID_W-1:0] RST_ROW_COUNT     = 9'd16;
  localparam logic [SIZE_W-1:0] RST_CELL_SIZE     = 16'd16;
  localparam logic [CNT_W-1:0]  RST_CELL_CAPACITY = 9'd256;

  // Actions
  localparam logic ACT_PLACE  = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_OK   = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL = 2'd1;
  localparam logic [ERR_W-1:0] ERR_SLOT = 2'd2;

  // Per-particle record
  typedef struct packed {
    logic [CELL_W-1:0] cell_idx;
    logic [SLOT_W-1:0] slot;
  } part_entry_t;

  // Sequencer states
  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_DIV     = 9'b000000010,
    ST_CLAMP   = 9'b000000100,
    ST_INDEX   = 9'b000001000,
    ST_RD_TGT  = 9'b000010000,
    ST_CHK_TGT = 9'b000100000,
    ST_CHK_OLD = 9'b001000000,
    ST_SWAP    = 9'b010000000,
    ST_APPEND  = 9'b100000000
  } state_t;

endpackage

@@ sv/ugbu_div.sv @@
// Restoring divider, one quotient bit per cycle
module ugbu_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ugbu_pkg::QUO_W-1:0]    dividend,
  input  logic [ugbu_pkg::SIZE_W-1:0]   divisor,
  output logic [ugbu_pkg::QUO_W-1:0]    quotient,
  output logic                          done
);

  localparam int W = ugbu_pkg::QUO_W;
  localparam int D = ugbu_pkg::SIZE_W;
  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] LAST = CW'(W - 1);

  logic          run_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [D-1:0]  rem_r;
  logic [W-1:0]  quo_r;   // dividend bits shift out, quotient bits shift in
  logic [D-1:0]  dsr_r;

  logic [D:0]    trial;
  logic          fits;
  logic [D-1:0]  rem_nxt;

  // Trial subtract
  always_comb begin
    trial   = {rem_r, quo_r[W-1]};
    fits    = (trial >= {1'b0, dsr_r});
    rem_nxt = fits ? D'(trial - {1'b0, dsr_r}) : trial[D-1:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[W-2:0], fits};
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

@@ sv/uniform_grid_bucket_update.sv @@
// Bins particles into a uniform 2D grid. Pulse start while busy is low with a particle
// number, an action (place or update) and a signed position with 8 fraction bits; one
// result follows on out_strobe for a single cycle and cannot be held off. An item goes
// through the column and row divisions by cell_size (15 bit-serial steps, both axes side
// by side, then the hand-off), then the clamp, the cell index and dependent registered
// reads and writes of the count, member list and particle memories. busy falls as the
// strobe rises, so the next item can be taken at the edge that ends the strobe. Member
// counts are cleared at reset through per-cell valid bits, so items may start right
// away. Write configuration only while the block is idle.
module uniform_grid_bucket_update (
  input  logic                               clk,
  input  logic                               rst_n,
  // command
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_action,
  input  logic [ugbu_pkg::PIDX_W-1:0]        in_particle_index,
  input  logic signed [ugbu_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [ugbu_pkg::POS_W-1:0]  in_pos_y,
  // result
  output logic                               out_strobe,
  output logic [ugbu_pkg::CELL_W-1:0]        out_cell_index,
  output logic                               out_moved,
  output logic [ugbu_pkg::SLOT_W-1:0]        out_slot_in_cell,
  output logic [ugbu_pkg::ERR_W-1:0]         out_error_code,
  // configuration
  input  logic                               cfg_we,
  input  logic [ugbu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ugbu_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int PIDX_W  = ugbu_pkg::PIDX_W;
  localparam int CELL_W  = ugbu_pkg::CELL_W;
  localparam int SLOT_W  = ugbu_pkg::SLOT_W;
  localparam int CNT_W   = ugbu_pkg::CNT_W;
  localparam int QUO_W   = ugbu_pkg::QUO_W;
  localparam int SIZE_W  = ugbu_pkg::SIZE_W;
  localparam int GRID_W  = ugbu_pkg::GRID_W;
  localparam int ERR_W   = ugbu_pkg::ERR_W;
  localparam int LIST_AW = ugbu_pkg::LIST_AW;
  localparam int IDX_W   = CELL_W + GRID_W;
  localparam int POS_MSB = ugbu_pkg::POS_W - 1;
  localparam int FRAC_W  = ugbu_pkg::FRAC_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [GRID_W-1:0] col_count_r;
  logic [GRID_W-1:0] row_count_r;
  logic [SIZE_W-1:0] cell_size_r;
  logic [CNT_W-1:0]  cell_cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= ugbu_pkg::RST_COLUMN_COUNT;
      row_count_r <= ugbu_pkg::RST_ROW_COUNT;
      cell_size_r <= ugbu_pkg::RST_CELL_SIZE;
      cell_cap_r  <= ugbu_pkg::RST_CELL_CAPACITY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ugbu_pkg::CFG_COLUMN_COUNT:  col_count_r <= cfg_wdata[GRID_W-1:0];
        ugbu_pkg::CFG_ROW_COUNT:     row_count_r <= cfg_wdata[GRID_W-1:0];
        ugbu_pkg::CFG_CELL_SIZE:     cell_size_r <= cfg_wdata[SIZE_W-1:0];
        ugbu_pkg::CFG_CELL_CAPACITY: cell_cap_r  <= cfg_wdata[CNT_W-1:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state and item registers
  ugbu_pkg::state_t state_r, state_nxt;

  logic                 accept;
  logic                 action_r;
  logic [PIDX_W-1:0]    pidx_r;
  logic [CELL_W-1:0]    col_r;
  logic [CELL_W-1:0]    row_r;
  logic [CELL_W-1:0]    tgt_cell_r;
  logic [CNT_W-1:0]     tgt_cnt_r;
  logic [CELL_W-1:0]    old_cell_r;
  logic [SLOT_W-1:0]    old_slot_r;
  logic [CNT_W-1:0]     old_cnt_r;

  assign accept = start && (state_r == ugbu_pkg::ST_IDLE);
  assign busy   = (state_r != ugbu_pkg::ST_IDLE);

  // ---------------------------------------------------------------------------
  // Column and row division; a negative coordinate divides zero
  logic [QUO_W-1:0]  div_x_a, div_y_a, div_x_q, div_y_q;
  logic [SIZE_W-1:0] div_d;
  logic              div_x_done, div_y_done;

  assign div_x_a = in_pos_x[POS_MSB] ? '0 : in_pos_x[POS_MSB-1:FRAC_W];
  assign div_y_a = in_pos_y[POS_MSB] ? '0 : in_pos_y[POS_MSB-1:FRAC_W];
  assign div_d   = (cell_size_r == '0) ? SIZE_W'(1) : cell_size_r;

  ugbu_div u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .dividend (div_x_a),
    .divisor  (div_d),
    .quotient (div_x_q),
    .done     (div_x_done)
  );

  ugbu_div u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .dividend (div_y_a),
    .divisor  (div_d),
    .quotient (div_y_q),
    .done     (div_y_done)
  );

  // Clamp a quotient to count-1, a count of zero acting as one
  function automatic logic [CELL_W-1:0] clamp_axis(input logic [QUO_W-1:0]  q,
                                                    input logic [GRID_W-1:0] n);
    logic [GRID_W-1:0] lim;
    logic [GRID_W-1:0] top;
    lim = (n == '0) ? GRID_W'(1) : n;
    top = lim - 1'b1;
    if (q > QUO_W'(top)) clamp_axis = top[CELL_W-1:0];
    else                 clamp_axis = q[CELL_W-1:0];
  endfunction

  logic [GRID_W-1:0] cols_eff;
  logic [IDX_W-1:0]  idx_sum;

  assign cols_eff = (col_count_r == '0) ? GRID_W'(1) : col_count_r;
  assign idx_sum  = IDX_W'(row_r) * IDX_W'(cols_eff) + IDX_W'(col_r);

  // ---------------------------------------------------------------------------
  // Memories
  // member counts, cleared at reset through per-cell valid bits
  logic [CNT_W-1:0]      cnt_mem [ugbu_pkg::MAX_CELLS];
  logic [ugbu_pkg::MAX_CELLS-1:0] cnt_vld_r;
  logic [CNT_W-1:0]      cnt_rdata_r;
  logic                  cnt_rvld_r;
  logic [CNT_W-1:0]      cnt_rd;
  logic [CELL_W-1:0]     cnt_raddr;
  logic                  cnt_we;
  logic [CELL_W-1:0]     cnt_waddr;
  logic [CNT_W-1:0]      cnt_wdata;

  // member lists, one row of slots per cell
  logic [PIDX_W-1:0]     list_mem [ugbu_pkg::MAX_CELLS * ugbu_pkg::MAX_PARTICLES];
  logic [PIDX_W-1:0]     list_rdata_r;
  logic [LIST_AW-1:0]    list_raddr;
  logic                  list_we;
  logic [LIST_AW-1:0]    list_waddr;
  logic [PIDX_W-1:0]     list_wdata;

  // per-particle cell and slot, fields written separately
  ugbu_pkg::part_entry_t part_mem [ugbu_pkg::MAX_PARTICLES];
  ugbu_pkg::part_entry_t part_rdata_r;
  ugbu_pkg::part_entry_t part_wdata;
  logic                  part_we_cell;
  logic                  part_we_slot;
  logic [PIDX_W-1:0]     part_waddr;

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_rdata_r <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r  <= '0;
      cnt_rvld_r <= 1'b0;
    end else begin
      if (cnt_we) cnt_vld_r[cnt_waddr] <= 1'b1;
      cnt_rvld_r <= cnt_vld_r[cnt_raddr];
    end
  end

  assign cnt_rd = cnt_rvld_r ? cnt_rdata_r : '0;

  always_ff @(posedge clk) begin
    if (list_we) list_mem[list_waddr] <= list_wdata;
    list_rdata_r <= list_mem[list_raddr];
  end

  always_ff @(posedge clk) begin
    if (part_we_cell) part_mem[part_waddr].cell_idx <= part_wdata.cell_idx;
    if (part_we_slot) part_mem[part_waddr].slot     <= part_wdata.slot;
    part_rdata_r <= part_mem[pidx_r];
  end

  // ---------------------------------------------------------------------------
  // Sequencer: steps are spaced so that no read meets a pending write
  logic              fin;
  logic              fin_moved;
  logic [SLOT_W-1:0] fin_slot;
  logic [ERR_W-1:0]  fin_err;
  logic              do_swap;
  logic              do_append;
  logic [CNT_W-1:0]  app_cnt;
  logic [CNT_W-1:0]  tgt_cnt_now;
  logic [CNT_W-1:0]  old_last;

  function automatic logic is_full(input logic [CNT_W-1:0] n,
                                   input logic [CNT_W-1:0] cap);
    is_full = n[CNT_W-1] || (n >= cap);
  endfunction

  assign tgt_cnt_now = cnt_rd;
  assign app_cnt     = (state_r == ugbu_pkg::ST_CHK_TGT) ? tgt_cnt_now : tgt_cnt_r;
  assign old_last    = cnt_rd - 1'b1;

  always_comb begin
    state_nxt  = state_r;
    fin        = 1'b0;
    fin_moved  = 1'b0;
    fin_slot   = '0;
    fin_err    = ugbu_pkg::ERR_OK;
    do_swap    = 1'b0;
    do_append  = 1'b0;
    cnt_raddr  = tgt_cell_r;
    list_raddr = {old_cell_r, old_last[SLOT_W-1:0]};
    unique case (state_r)
      ugbu_pkg::ST_IDLE: begin
        if (start) state_nxt = ugbu_pkg::ST_DIV;
      end
      ugbu_pkg::ST_DIV: begin
        if (div_x_done) state_nxt = ugbu_pkg::ST_CLAMP;
      end
      ugbu_pkg::ST_CLAMP:  state_nxt = ugbu_pkg::ST_INDEX;
      ugbu_pkg::ST_INDEX:  state_nxt = ugbu_pkg::ST_RD_TGT;
      ugbu_pkg::ST_RD_TGT: state_nxt = ugbu_pkg::ST_CHK_TGT;
      ugbu_pkg::ST_CHK_TGT: begin
        if (action_r == ugbu_pkg::ACT_PLACE) begin
          fin       = 1'b1;
          state_nxt = ugbu_pkg::ST_IDLE;
          if (is_full(tgt_cnt_now, cell_cap_r)) begin
            fin_err = ugbu_pkg::ERR_FULL;
          end else begin
            do_append = 1'b1;
            fin_moved = 1'b1;
            fin_slot  = tgt_cnt_now[SLOT_W-1:0];
          end
        end else if (part_rdata_r.cell_idx == tgt_cell_r) begin
          // same cell: report the recorded slot
          fin       = 1'b1;
          fin_slot  = part_rdata_r.slot;
          state_nxt = ugbu_pkg::ST_IDLE;
        end else begin
          cnt_raddr = part_rdata_r.cell_idx;
          state_nxt = ugbu_pkg::ST_CHK_OLD;
        end
      end
      ugbu_pkg::ST_CHK_OLD: begin
        // slot check before the full check
        if (CNT_W'(old_slot_r) >= cnt_rd) begin
          fin       = 1'b1;
          fin_err   = ugbu_pkg::ERR_SLOT;
          state_nxt = ugbu_pkg::ST_IDLE;
        end else if (is_full(tgt_cnt_r, cell_cap_r)) begin
          fin       = 1'b1;
          fin_err   = ugbu_pkg::ERR_FULL;
          state_nxt = ugbu_pkg::ST_IDLE;
        end else begin
          state_nxt = ugbu_pkg::ST_SWAP;
        end
      end
      ugbu_pkg::ST_SWAP: begin
        do_swap   = 1'b1;
        state_nxt = ugbu_pkg::ST_APPEND;
      end
      ugbu_pkg::ST_APPEND: begin
        do_append = 1'b1;
        fin       = 1'b1;
        fin_moved = 1'b1;
        fin_slot  = tgt_cnt_r[SLOT_W-1:0];
        state_nxt = ugbu_pkg::ST_IDLE;
      end
      default: state_nxt = ugbu_pkg::ST_IDLE;
    endcase
  end

  // Write ports: swap moves the last member into the vacated slot, append adds p
  always_comb begin
    cnt_we              = do_swap || do_append;
    cnt_waddr           = do_swap ? old_cell_r : tgt_cell_r;
    cnt_wdata           = do_swap ? (old_cnt_r - 1'b1) : (app_cnt + 1'b1);

    list_we             = do_swap || do_append;
    list_waddr          = do_swap ? {old_cell_r, old_slot_r} : {tgt_cell_r, app_cnt[SLOT_W-1:0]};
    list_wdata          = do_swap ? list_rdata_r : pidx_r;

    part_we_cell        = do_append;
    part_we_slot        = do_swap || do_append;
    part_waddr          = do_swap ? list_rdata_r : pidx_r;
    part_wdata.cell_idx = tgt_cell_r;
    part_wdata.slot     = do_swap ? old_slot_r : app_cnt[SLOT_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Control and item registers
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ugbu_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action_r <= in_action;
      pidx_r   <= in_particle_index;
    end
    if (state_r == ugbu_pkg::ST_CLAMP) begin
      col_r <= clamp_axis(div_x_q, col_count_r);
      row_r <= clamp_axis(div_y_q, row_count_r);
    end
    if (state_r == ugbu_pkg::ST_INDEX) tgt_cell_r <= idx_sum[CELL_W-1:0];
    if (state_r == ugbu_pkg::ST_CHK_TGT) begin
      tgt_cnt_r  <= tgt_cnt_now;
      old_cell_r <= part_rdata_r.cell_idx;
      old_slot_r <= part_rdata_r.slot;
    end
    if (state_r == ugbu_pkg::ST_CHK_OLD) old_cnt_r <= cnt_rd;
  end

  // ---------------------------------------------------------------------------
  // Result register
  logic              out_strobe_r;
  logic [CELL_W-1:0] out_cell_r;
  logic              out_moved_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [ERR_W-1:0]  out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe_r <= 1'b0;
    else        out_strobe_r <= fin;
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_cell_r  <= tgt_cell_r;
      out_moved_r <= fin_moved;
      out_slot_r  <= fin_slot;
      out_err_r   <= fin_err;
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_cell_index   = out_cell_r;
  assign out_moved        = out_moved_r;
  assign out_slot_in_cell = out_slot_r;
  assign out_error_code   = out_err_r;

  // ---------------------------------------------------------------------------
  // Assertions
  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without an item in progress");

  a_error_no_move: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_error_code != ugbu_pkg::ERR_OK)) |->
      (!out_moved && (out_slot_in_cell == '0)))
    else $error("error result reports a move or a slot");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy && !out_strobe))
    else $error("accepted item did not make the block busy");

  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    div_x_done == div_y_done)
    else $error("column and row dividers out of step");

endmodule

@@ tb/sv/uniform_grid_bucket_update_tb.sv @@
module uniform_grid_bucket_update_tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 190;
  localparam int PHASE_COUNT  = 10;
  localparam int IDLE_PCT     = 37;

  localparam int PIDX_W     = ugbu_pkg::PIDX_W;
  localparam int CELL_W     = ugbu_pkg::CELL_W;
  localparam int SLOT_W     = ugbu_pkg::SLOT_W;
  localparam int ERR_W      = ugbu_pkg::ERR_W;
  localparam int POS_W      = ugbu_pkg::POS_W;
  localparam int FRAC_W     = ugbu_pkg::FRAC_W;
  localparam int CFG_IDX_W  = ugbu_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = ugbu_pkg::CFG_DATA_W;
  localparam int MAX_CELLS     = ugbu_pkg::MAX_CELLS;
  localparam int MAX_PARTICLES = ugbu_pkg::MAX_PARTICLES;

  typedef struct {
    logic [CELL_W-1:0] cell_index;
    logic              moved;
    logic [SLOT_W-1:0] slot_in_cell;
    logic [ERR_W-1:0]  error_code;
  } bin_result_t;

  // Block ports
  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_action = ugbu_pkg::ACT_PLACE;
  logic [PIDX_W-1:0]     in_particle_index = '0;
  logic signed [POS_W-1:0] in_pos_x = '0;
  logic signed [POS_W-1:0] in_pos_y = '0;
  logic                  out_strobe;
  logic [CELL_W-1:0]     out_cell_index;
  logic                  out_moved;
  logic [SLOT_W-1:0]     out_slot_in_cell;
  logic [ERR_W-1:0]      out_error_code;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shadow of the configuration registers
  int unsigned grid_cols = 32'(ugbu_pkg::RST_COLUMN_COUNT);
  int unsigned grid_rows = 32'(ugbu_pkg::RST_ROW_COUNT);
  int unsigned cell_edge = 32'(ugbu_pkg::RST_CELL_SIZE);
  int unsigned cell_cap  = 32'(ugbu_pkg::RST_CELL_CAPACITY);

  // Shadow of the binning state
  int unsigned       members[MAX_CELLS];
  logic [PIDX_W-1:0] member_list[MAX_CELLS][MAX_PARTICLES];
  logic [CELL_W-1:0] home_cell[MAX_PARTICLES];
  logic [SLOT_W-1:0] home_slot[MAX_PARTICLES];
  bit                placed[MAX_PARTICLES];
  int unsigned       placed_ids[$];

  bin_result_t binning_due[$];
  int          mismatches  = 0;
  int          cycle_count = 0;

  uniform_grid_bucket_update dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_particle_index(in_particle_index),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .out_strobe       (out_strobe),
    .out_cell_index   (out_cell_index),
    .out_moved        (out_moved),
    .out_slot_in_cell (out_slot_in_cell),
    .out_error_code   (out_error_code),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("uniform_grid_bucket_update_tb: errors");
      $finish;
    end
  end

  // Column or row of one coordinate: negative gives 0, else quotient clamped to the grid
  function automatic int unsigned grid_axis(logic [POS_W-1:0] raw, int unsigned limit);
    int unsigned sz;
    int unsigned n;
    int unsigned q;
    sz = (cell_edge == 0) ? 1 : cell_edge;
    n  = (limit == 0) ? 1 : limit;
    if (raw[POS_W-1])
      return 0;
    q = 32'(raw[POS_W-2:FRAC_W]);
    q = q / sz;
    return (q > n - 1) ? n - 1 : q;
  endfunction

  function automatic bit bin_is_full(int unsigned tgt);
    return members[tgt] >= cell_cap || members[tgt] >= MAX_PARTICLES;
  endfunction

  function automatic logic [SLOT_W-1:0] append_member(int unsigned tgt,
                                                      logic [PIDX_W-1:0] p);
    int unsigned s;
    s = members[tgt];
    member_list[tgt][s] = p;
    members[tgt] = s + 1;
    home_slot[p] = s[SLOT_W-1:0];
    home_cell[p] = tgt[CELL_W-1:0];
    if (!placed[p]) begin
      placed[p] = 1'b1;
      placed_ids.push_back(32'(p));
    end
    return s[SLOT_W-1:0];
  endfunction

  // Expected outcome of one place or update, applied to the shadow state
  function automatic bin_result_t bin_particle(logic act, logic [PIDX_W-1:0] p,
                                               logic [POS_W-1:0] px, logic [POS_W-1:0] py);
    bin_result_t r;
    int unsigned cols;
    int unsigned tgt;
    int unsigned old_bin;
    int unsigned pos;
    int unsigned cnt;
    logic [PIDX_W-1:0] last;
    cols = (grid_cols == 0) ? 1 : grid_cols;
    tgt  = (grid_axis(py, grid_rows) * cols + grid_axis(px, grid_cols)) % MAX_CELLS;
    r.cell_index   = tgt[CELL_W-1:0];
    r.moved        = 1'b0;
    r.slot_in_cell = '0;
    r.error_code   = ugbu_pkg::ERR_OK;
    if (act == ugbu_pkg::ACT_PLACE) begin
      if (bin_is_full(tgt)) begin
        r.error_code = ugbu_pkg::ERR_FULL;
      end else begin
        r.slot_in_cell = append_member(tgt, p);
        r.moved = 1'b1;
      end
    end else begin
      old_bin = 32'(home_cell[p]);
      if (old_bin == tgt) begin
        r.slot_in_cell = home_slot[p];
      end else begin
        pos = 32'(home_slot[p]);
        cnt = members[old_bin];
        if (pos >= cnt) begin
          r.error_code = ugbu_pkg::ERR_SLOT;
        end else if (bin_is_full(tgt)) begin
          r.error_code = ugbu_pkg::ERR_FULL;
        end else begin
          // leave the old cell by swap-with-last
          last = member_list[old_bin][cnt-1];
          member_list[old_bin][pos] = last;
          members[old_bin] = cnt - 1;
          home_slot[last] = pos[SLOT_W-1:0];
          r.slot_in_cell = append_member(tgt, p);
          r.moved = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Random coordinate: mostly inside the grid, some anywhere, some negative
  function automatic logic [POS_W-1:0] pick_coord(int unsigned count);
    int unsigned n;
    int unsigned sz;
    int unsigned lim;
    int unsigned mode;
    logic [31:0] ip;
    logic [31:0] fr;
    n  = (count == 0) ? 1 : count;
    sz = (cell_edge == 0) ? 1 : cell_edge;
    lim = n * sz + sz;
    if (lim > 32767)
      lim = 32767;
    mode = $urandom_range(0, 99);
    ip = $urandom_range(0, lim);
    fr = $urandom;
    if (mode < 70)
      return {1'b0, ip[14:0], fr[7:0]};
    else if (mode < 85)
      return fr[POS_W-1:0];
    else
      return {1'b1, fr[POS_W-2:0]};
  endfunction

  // One item transfer; called and returns at a falling edge
  task automatic send_item(logic act, logic [PIDX_W-1:0] p,
                           logic [POS_W-1:0] px, logic [POS_W-1:0] py);
    in_action         = act;
    in_particle_index = p;
    in_pos_x          = px;
    in_pos_y          = py;
    start             = 1'b1;
    while (busy)
      @(negedge clk);
    // busy is low and stays so until the rising edge that takes the item
    binning_due.push_back(bin_particle(act, p, px, py));
    @(posedge clk);
    @(negedge clk);
    start = 1'b0;
  endtask

  // Wait until every expected result has come and the block is idle
  task automatic drain();
    while (binning_due.size() != 0 || busy)
      @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val[CFG_DATA_W-1:0];
    case (idx)
      ugbu_pkg::CFG_COLUMN_COUNT:  grid_cols = val & 32'h1FF;
      ugbu_pkg::CFG_ROW_COUNT:     grid_rows = val & 32'h1FF;
      ugbu_pkg::CFG_CELL_SIZE:     cell_edge = val & 32'hFFFF;
      ugbu_pkg::CFG_CELL_CAPACITY: cell_cap  = val & 32'h1FF;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_grid(int unsigned cols, int unsigned rows, int unsigned sz,
                          int unsigned cap);
    write_reg(ugbu_pkg::CFG_COLUMN_COUNT, cols);
    write_reg(ugbu_pkg::CFG_ROW_COUNT, rows);
    write_reg(ugbu_pkg::CFG_CELL_SIZE, sz);
    write_reg(ugbu_pkg::CFG_CELL_CAPACITY, cap);
  endtask

  // Field extremes, both actions, same-cell update and a repeated place
  task automatic test_field_extremes();
    send_item(ugbu_pkg::ACT_PLACE,  8'd0,   24'h000000, 24'h000000);
    send_item(ugbu_pkg::ACT_PLACE,  8'd255, 24'h7FFFFF, 24'h7FFFFF);
    send_item(ugbu_pkg::ACT_PLACE,  8'd1,   24'h800000, 24'h800000);
    send_item(ugbu_pkg::ACT_PLACE,  8'd2,   24'h000FFF, 24'h0010FF);
    send_item(ugbu_pkg::ACT_UPDATE, 8'd255, 24'h000000, 24'h000000);
    send_item(ugbu_pkg::ACT_UPDATE, 8'd0,   24'h0000FF, 24'h000000);
    send_item(ugbu_pkg::ACT_UPDATE, 8'd1,   24'hFFFFFF, 24'h7FFF00);
    send_item(ugbu_pkg::ACT_PLACE,  8'd0,   24'h00F000, 24'h000000);
  endtask

  // A stale list entry swapped into place leaves a slot beyond its cell's count
  task automatic test_stale_slot();
    send_item(ugbu_pkg::ACT_PLACE,  8'd10, 24'h005000, 24'h000000);
    send_item(ugbu_pkg::ACT_PLACE,  8'd11, 24'h005000, 24'h000000);
    send_item(ugbu_pkg::ACT_PLACE,  8'd12, 24'h005000, 24'h000000);
    send_item(ugbu_pkg::ACT_PLACE,  8'd13, 24'h005000, 24'h000000);
    send_item(ugbu_pkg::ACT_PLACE,  8'd13, 24'h006000, 24'h000000);
    send_item(ugbu_pkg::ACT_UPDATE, 8'd12, 24'h007000, 24'h000000);
    send_item(ugbu_pkg::ACT_UPDATE, 8'd13, 24'h008000, 24'h000000);
  endtask

  // Full cells on place and update, and capacity shrunk below a count
  task automatic test_capacity();
    drain();
    write_reg(ugbu_pkg::CFG_CELL_CAPACITY, 2);
    send_item(ugbu_pkg::ACT_PLACE,  8'd20, 24'h009000, 24'h000000);
    send_item(ugbu_pkg::ACT_PLACE,  8'd21, 24'h009000, 24'h000000);
    send_item(ugbu_pkg::ACT_PLACE,  8'd22, 24'h009000, 24'h000000);
    send_item(ugbu_pkg::ACT_PLACE,  8'd22, 24'h00A000, 24'h000000);
    send_item(ugbu_pkg::ACT_UPDATE, 8'd22, 24'h009000, 24'h000000);
    drain();
    write_reg(ugbu_pkg::CFG_CELL_CAPACITY, 1);
    send_item(ugbu_pkg::ACT_UPDATE, 8'd20, 24'h00A000, 24'h000000);
    send_item(ugbu_pkg::ACT_UPDATE, 8'd22, 24'h00A080, 24'h000000);
  endtask

  // Phases of random places and updates under varied grids
  task automatic test_random();
    int unsigned cols;
    int unsigned rows;
    int unsigned sz;
    int unsigned cap;
    int unsigned idle_pct;
    int unsigned pool;
    int unsigned base;
    int unsigned p;
    logic        act;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      idle_pct = IDLE_PCT;
      pool = $urandom_range(6, 40);
      base = $urandom_range(0, 255);
      case (ph)
        0: begin cols = 1;   rows = 256; sz = 1;     cap = 511; end
        1: begin cols = 256; rows = 1;   sz = 65535; cap = 255; end
        2: begin cols = 0;   rows = 0;   sz = 0;     cap = 1;   end
        3: begin cols = 511; rows = 511; sz = 2;     cap = 0;   end
        4: begin
          cols = 16; rows = 16; sz = 16; cap = 256;
          idle_pct = 0;
        end
        default: begin
          cols = ($urandom_range(0, 9) == 0) ? 256 : $urandom_range(1, 24);
          rows = $urandom_range(1, 12);
          sz   = $urandom_range(1, 48);
          cap  = $urandom_range(0, 1) ? $urandom_range(1, 10) : 256;
        end
      endcase
      drain();
      set_grid(cols, rows, sz, cap);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // now and then hold off until the block has delivered everything
        if ($urandom_range(0, 99) == 0)
          drain();
        if ($urandom_range(0, 99) < idle_pct)
          repeat ($urandom_range(1, 30)) @(negedge clk);
        if (placed_ids.size() == 0 || $urandom_range(0, 99) < 35) begin
          act = ugbu_pkg::ACT_PLACE;
          p   = (base + $urandom_range(0, pool - 1)) % MAX_PARTICLES;
        end else begin
          act = ugbu_pkg::ACT_UPDATE;
          p   = placed_ids[$urandom_range(0, placed_ids.size() - 1)];
        end
        send_item(act, p[PIDX_W-1:0], pick_coord(grid_cols), pick_coord(grid_rows));
      end
    end
  endtask

  // Result checking against the oldest expectation
  always @(posedge clk) begin : check_results
    bin_result_t want;
    if (rst_n && out_strobe) begin
      if (binning_due.size() == 0) begin
        $error("result with none expected: cell_index %0d", out_cell_index);
        mismatches++;
      end else begin
        want = binning_due.pop_front();
        if (out_cell_index !== want.cell_index) begin
          $error("cell_index: expected %0d, got %0d", want.cell_index, out_cell_index);
          mismatches++;
        end
        if (out_moved !== want.moved) begin
          $error("moved: expected %0d, got %0d", want.moved, out_moved);
          mismatches++;
        end
        if (out_slot_in_cell !== want.slot_in_cell) begin
          $error("slot_in_cell: expected %0d, got %0d", want.slot_in_cell, out_slot_in_cell);
          mismatches++;
        end
        if (out_error_code !== want.error_code) begin
          $error("error_code: expected %0d, got %0d", want.error_code, out_error_code);
          mismatches++;
        end
      end
    end
  end

  initial begin
    foreach (members[i])
      members[i] = 0;
    foreach (home_cell[i]) begin
      home_cell[i] = '0;
      home_slot[i] = '0;
      placed[i]    = 1'b0;
    end
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_field_extremes();
    test_stale_slot();
    test_capacity();
    test_random();

    drain();
    repeat (30) @(negedge clk);
    if (mismatches == 0)
      $display("uniform_grid_bucket_update_tb: clean");
    else
      $display("uniform_grid_bucket_update_tb: errors");
    $finish;
  end

endmodule
